// ===== hdl/integer_to_radix_symbols_defines.svh =====
// assertion macros shared by the radix symbol converter rtl
// no dependencies; included by the modules that check their own logic
`ifndef INTEGER_TO_RADIX_SYMBOLS_DEFINES_SVH
`define INTEGER_TO_RADIX_SYMBOLS_DEFINES_SVH
`ifndef SYNTH
`define ITRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITRS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ITRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ITRS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hdl/itrs_pkg.sv =====
// shared types and constants for the radix symbol converter
// no dependencies
package itrs_pkg;

    localparam int MAG_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 8;
    localparam int SLOT_W     = 7;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = MAG_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int MAX_DIGITS = MAG_W;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        OUT_MINUS,
        OUT_DIGIT,
        OUT_BAD
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SIGN,
        ST_DIV,
        ST_STORE,
        ST_DRD,
        ST_SRD,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic     sym_wr;
        logic     start;
        logic     chk_run;
        logic     div_step;
        logic     dig_store;
        logic     dig_rd;
        logic     sym_rd_dig;
        logic     out_load;
        out_sel_t out_sel;
    } itrs_cmd_t;

    typedef struct packed {
        logic chk_done;
        logic chk_bad;
        logic neg;
        logic div_last;
        logic quo_zero;
        logic dig_empty;
        logic out_free;
    } itrs_sts_t;

endpackage

// ===== hdl/itrs_if.sv =====
// valid/ready channels of the radix symbol converter
// depends on itrs_pkg
interface itrs_req_if
    import itrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [SLOT_W-1:0]        slot;
    logic [CHAR_W-1:0]        symbol;
    logic signed [MAG_W-1:0]  number;

    modport source (output valid, op, slot, symbol, number, input ready);
    modport sink   (input valid, op, slot, symbol, number, output ready);
endinterface

interface itrs_rsp_if
    import itrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_base;

    modport source (output valid, character, last, bad_base, input ready);
    modport sink   (input valid, character, last, bad_base, output ready);
endinterface

// ===== hdl/integer_to_radix_symbols.sv =====
// integer to radix symbols: writes a signed 32-bit number in a user-defined digit alphabet
// top level; depends on itrs_pkg, itrs_if, itrs_ram, itrs_dp and itrs_ctrl
//
// req channel (valid/ready): op = 0 writes symbol into table position slot, op = 1 converts
// number. rsp channel (valid/ready): one transfer per character, '-' first for a negative
// number, then the digits most significant first; last marks the final one. A base that
// fails the check (fewer than two symbols, more than the table, a non-printable symbol,
// '+', '-', or a repeat) gives a single transfer with bad_base = 1 and last = 1.
// cfg_wr_en/cfg_wr_data write the number of symbols in use; write it only while idle.
// a load writes the table when it is taken and leaves the block idle. a conversion walks
// up to base_length table entries at one per cycle (symbol ram read port), then per digit runs
// DIV_STEPS divider steps of 4 quotient bits each plus a store step, then reads each digit
// out through ST_DRD (digit read), ST_SRD (symbol read) and ST_PUT (result load).
// req is taken only between conversions; the result register lets the next item in
// while the final transfer still waits.
// when rsp.ready is low the block holds the current result and pauses the readout.
// reset clears the state machine, the result valid and base_length; table contents
// are undefined until loaded.
module integer_to_radix_symbols
    import itrs_pkg::*;
#(
    parameter int SYMBOL_SLOTS = 128,
    parameter int DIGIT_SLOTS  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    itrs_req_if.sink          req,
    itrs_rsp_if.source        rsp,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data
);

    itrs_cmd_t cmd;
    itrs_sts_t sts;
    logic      in_ready;

    assign req.ready = in_ready;

    itrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itrs_dp #(
        .SYMBOL_SLOTS (SYMBOL_SLOTS),
        .DIGIT_SLOTS  (DIGIT_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== hdl/itrs_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module itrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/itrs_dp.sv =====
// datapath: symbol table, base check, radix divider, digit buffer, result register
// depends on itrs_pkg, itrs_if, itrs_ram and the assertion macros
`include "integer_to_radix_symbols_defines.svh"

module itrs_dp
    import itrs_pkg::*;
#(
    parameter int SYMBOL_SLOTS = 128,
    parameter int DIGIT_SLOTS  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    itrs_req_if.sink          req,
    itrs_rsp_if.source        rsp,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data,
    input  itrs_cmd_t         cmd,
    output itrs_sts_t         sts
);

    localparam int SYM_AW = $clog2(SYMBOL_SLOTS);
    localparam int DIG_AW = $clog2(DIGIT_SLOTS);
    localparam int CNT_W  = $clog2(DIGIT_SLOTS + 1);
    localparam logic [BASE_W:0] SLOTS_LIM = (BASE_W + 1)'(SYMBOL_SLOTS);

    logic [BASE_W-1:0]    base_reg;
    logic [BASE_W-1:0]    chk_idx_reg;
    logic                 chk_pend_reg;
    logic                 chk_bad_reg;
    logic [255:0]         seen_reg;
    logic                 neg_reg;
    logic [MAG_W-1:0]     quo_reg;
    logic [BASE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0]     dig_cnt_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 out_last_reg;
    logic                 out_bad_reg;

    logic [MAG_W-1:0]     num_u;
    logic [MAG_W-1:0]     mag_in;
    logic                 range_bad;
    logic                 chk_issue;
    logic [CHAR_W-1:0]    sym_rd_data;
    logic                 sym_bad;
    logic [BASE_W:0]      slot_ext;
    logic                 sym_wr_en;
    logic                 sym_rd_en;
    logic [SYM_AW-1:0]    sym_rd_addr;
    logic [SYM_AW-1:0]    dig_rd_data;
    logic                 dig_wr_en;
    logic [CNT_W-1:0]     dig_cnt_m1;
    logic [MAG_W-1:0]     quo_next;
    logic [BASE_W-1:0]    rem_next;
    logic [BASE_W:0]      trial;
    logic                 out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    // symbol table
    assign slot_ext    = (BASE_W + 1)'(req.slot);
    assign sym_wr_en   = cmd.sym_wr && (slot_ext < SLOTS_LIM);
    assign chk_issue   = cmd.chk_run && !chk_bad_reg && (chk_idx_reg < base_reg);
    assign sym_rd_en   = chk_issue || cmd.sym_rd_dig;
    assign sym_rd_addr = cmd.sym_rd_dig ? dig_rd_data : chk_idx_reg[SYM_AW-1:0];

    itrs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (SYMBOL_SLOTS)
    ) u_sym_ram (
        .clk     (clk),
        .wr_en   (sym_wr_en),
        .wr_addr (slot_ext[SYM_AW-1:0]),
        .wr_data (req.symbol),
        .rd_en   (sym_rd_en),
        .rd_addr (sym_rd_addr),
        .rd_data (sym_rd_data)
    );

    // base check, one table entry per cycle; seen_reg marks symbols already met
    assign range_bad = (base_reg < BASE_W'(2)) || ((BASE_W + 1)'(base_reg) > SLOTS_LIM);
    assign sym_bad   = (sym_rd_data == CH_PLUS) || (sym_rd_data == CH_MINUS)
                    || (sym_rd_data < CH_SPACE) || (sym_rd_data > CH_TILDE)
                    || seen_reg[sym_rd_data];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_idx_reg  <= '0;
            chk_pend_reg <= 1'b0;
            chk_bad_reg  <= 1'b0;
            seen_reg     <= '0;
        end
        else if (cmd.start)
        begin
            chk_idx_reg  <= '0;
            chk_pend_reg <= 1'b0;
            chk_bad_reg  <= range_bad;
            seen_reg     <= '0;
        end
        else
        begin
            chk_pend_reg <= chk_issue;
            if (chk_issue)
            begin
                chk_idx_reg <= chk_idx_reg + BASE_W'(1);
            end
            if (chk_pend_reg)
            begin
                seen_reg[sym_rd_data] <= 1'b1;
                if (sym_bad)
                begin
                    chk_bad_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude, most negative number wraps to 2^31 unsigned
    assign num_u  = $unsigned(req.number);
    assign mag_in = num_u[MAG_W-1] ? (~num_u + MAG_W'(1)) : num_u;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_next, quo_next[MAG_W-1]};
            quo_next = {quo_next[MAG_W-2:0], 1'b0};
            if (trial >= (BASE_W + 1)'(base_reg))
            begin
                trial       = trial - (BASE_W + 1)'(base_reg);
                quo_next[0] = 1'b1;
            end
            rem_next = trial[BASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            div_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        else if (cmd.dig_store)
        begin
            div_cnt_reg <= '0;
            if (dig_wr_en)
            begin
                dig_cnt_reg <= dig_cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.dig_rd)
        begin
            dig_cnt_reg <= dig_cnt_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            neg_reg <= num_u[MAG_W-1];
            quo_reg <= mag_in;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        else if (cmd.dig_store)
        begin
            rem_reg <= '0;
        end
    end

    // digit buffer, least significant digit first
    assign dig_wr_en  = cmd.dig_store && (dig_cnt_reg < CNT_W'(DIGIT_SLOTS));
    assign dig_cnt_m1 = dig_cnt_reg - CNT_W'(1);

    itrs_ram #(
        .WIDTH (SYM_AW),
        .DEPTH (DIGIT_SLOTS)
    ) u_dig_ram (
        .clk     (clk),
        .wr_en   (dig_wr_en),
        .wr_addr (dig_cnt_reg[DIG_AW-1:0]),
        .wr_data (rem_reg[SYM_AW-1:0]),
        .rd_en   (cmd.dig_rd),
        .rd_addr (dig_cnt_m1[DIG_AW-1:0]),
        .rd_data (dig_rd_data)
    );

    // result register
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OUT_MINUS:
                begin
                    out_char_reg <= CH_MINUS;
                    out_last_reg <= 1'b0;
                    out_bad_reg  <= 1'b0;
                end
                OUT_DIGIT:
                begin
                    out_char_reg <= sym_rd_data;
                    out_last_reg <= (dig_cnt_reg == '0);
                    out_bad_reg  <= 1'b0;
                end
                default:
                begin
                    out_char_reg <= CH_NONE;
                    out_last_reg <= 1'b1;
                    out_bad_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.character = out_char_reg;
    assign rsp.last      = out_last_reg;
    assign rsp.bad_base  = out_bad_reg;

    assign sts.chk_done  = !chk_pend_reg && (chk_bad_reg || (chk_idx_reg >= base_reg));
    assign sts.chk_bad   = chk_bad_reg;
    assign sts.neg       = neg_reg;
    assign sts.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.quo_zero  = (quo_reg == '0);
    assign sts.dig_empty = (dig_cnt_reg == '0);
    assign sts.out_free  = out_free;

    `ITRS_ASSERT(a_bad_is_last, clk, rst_n, (out_valid_reg && out_bad_reg) |-> out_last_reg, "bad base result not marked last")
    `ITRS_ASSERT_NEVER(a_dig_bound, clk, rst_n, dig_cnt_reg > CNT_W'(MAX_DIGITS), "digit count beyond 32")
    `ITRS_ASSERT(a_rem_below_base, clk, rst_n, cmd.dig_store |-> (rem_reg < base_reg), "stored digit not below base")

endmodule

// ===== hdl/itrs_ctrl.sv =====
// controller state machine: sequences check, division, digit readout and results
// depends on itrs_pkg and the assertion macros
`include "integer_to_radix_symbols_defines.svh"

module itrs_ctrl
    import itrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_op,
    output logic      in_ready,
    input  itrs_sts_t sts,
    output itrs_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_DIGIT;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op_t'(in_op) == OP_LOAD)
                    begin
                        cmd.sym_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.chk_run = 1'b1;
                if (sts.chk_done)
                begin
                    if (!sts.chk_bad)
                    begin
                        state_next = ST_SIGN;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_BAD;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SIGN:
            begin
                if (!sts.neg)
                begin
                    state_next = ST_DIV;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_MINUS;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.dig_store = 1'b1;
                state_next    = sts.quo_zero ? ST_DRD : ST_DIV;
            end
            ST_DRD:
            begin
                cmd.dig_rd = 1'b1;
                state_next = ST_SRD;
            end
            ST_SRD:
            begin
                cmd.sym_rd_dig = 1'b1;
                state_next     = ST_PUT;
            end
            ST_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_DIGIT;
                    state_next   = sts.dig_empty ? ST_IDLE : ST_DRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ITRS_ASSERT(a_load_when_free, clk, rst_n, cmd.out_load |-> sts.out_free, "result loaded over a pending one")
    `ITRS_ASSERT(a_last_to_idle, clk, rst_n, (state_reg == ST_PUT && cmd.out_load && sts.dig_empty) |=> (state_reg == ST_IDLE), "no return to idle after last digit")
    `ITRS_ASSERT_NEVER(a_rd_empty, clk, rst_n, cmd.dig_rd && sts.dig_empty, "digit read from empty buffer")

endmodule
